@@ rtl/qlmc_pkg.sv @@
`timescale 1ns / 1ps

package qlmc_pkg;

  // Cache geometry default
  localparam int unsigned CacheSlotsDef = 8;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_ETX    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_DELAY  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_JITTER = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_REL    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_BW     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FRESH         = 3'd5;

  // Register reset values
  localparam logic [3:0]  WeightEtxRst    = 4'd4;
  localparam logic [3:0]  WeightDelayRst  = 4'd3;
  localparam logic [3:0]  WeightJitterRst = 4'd2;
  localparam logic [3:0]  WeightRelRst    = 4'd3;
  localparam logic [3:0]  WeightBwRst     = 4'd2;
  localparam logic [31:0] FreshRst        = 32'd1024;

  // Metric derivation constants
  localparam logic [15:0] DelayBias = 16'd10;
  localparam logic [7:0]  RelMax    = 8'd100;
  localparam logic [7:0]  BwMax     = 8'd250;
  localparam logic [8:0]  CostSpan  = 9'd256;

  // Shared rank unit widths
  localparam int unsigned OpW  = 16;
  localparam int unsigned WgtW = 4;
  localparam int unsigned AccW = 21;

  typedef enum logic [0:0] {
    FUNC_UPDATE = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  neighbor_id;
    logic [7:0]  link_cost;
    logic [15:0] queue_wait;
    logic [31:0] now;
  } qlmc_in_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  etx_out;
    logic [15:0] delay_out;
    logic [15:0] jitter_out;
    logic [6:0]  reliability_out;
    logic [7:0]  bandwidth_out;
    logic [15:0] rank_out;
  } qlmc_out_t;

  // One cache slot as kept in the slot RAM
  typedef struct packed {
    logic [7:0]  neighbor;
    logic [7:0]  etx;
    logic [15:0] delay;
    logic [15:0] jitter;
    logic [6:0]  reliability;
    logic [7:0]  bandwidth;
    logic [31:0] stamp;
  } slot_rec_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic            en;
    logic            clr;
    logic [OpW-1:0]  operand;
    logic [WgtW-1:0] weight;
  } mac_ctl_t;

endpackage

@@ rtl/qlmc_ram.sv @@
`timescale 1ns / 1ps

module qlmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Single write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/qlmc_mac.sv @@
`timescale 1ns / 1ps

module qlmc_mac
  import qlmc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mac_ctl_t        ctl_i,
  output logic [AccW-1:0] acc_o
);

  logic [AccW-1:0]       acc_q, acc_d;
  logic [OpW+WgtW-1:0]   prod;

  // One 16x4 product per cycle while en is high, added into the running sum
  assign prod = ctl_i.operand * ctl_i.weight;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.en) begin
      acc_d = (ctl_i.clr ? '0 : acc_q) + AccW'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/qos_link_metric_cache.sv @@
`timescale 1ns / 1ps
// Per-neighbor link metric derivation with a small freshness-checked cache.
// Input channel (in_valid_i / in_stall_o, payload in_data_i): an item is an
// update (derive delay, jitter, reliability, bandwidth and store them with
// the time stamp) or a lookup (return the first cached match if fresh).
// Output channel (out_valid_o / out_stall_i, payload out_data_o): one
// result item per input item, carrying the metrics and the weighted rank.
// Config channel (cfg_valid_i / cfg_ready_o): weights and freshness
// interval, written by index; ready is always high.
// The slots are searched one per cycle through the slot RAM read port,
// and the rank takes five steps of one shared multiply-accumulate unit.
// An update derives, writes its slot and ranks; a fresh lookup ranks the
// cached metrics; a miss or stale entry skips the rank. The block returns
// to idle before the next item is taken. One item is in work at a time.
// The result sits in an output register: a stalled receiver holds it there
// while the next item is already being worked on; the core waits only when
// it has a new result and the register is still full.
// Reset clears all cache slots (valid bits), the replace pointer, the
// previous delay and restores the register defaults.

module qos_link_metric_cache
  import qlmc_pkg::*;
#(
  parameter int unsigned CACHE_SLOTS = CacheSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qlmc_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qlmc_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned AW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam logic [AW-1:0] LastSlot = AW'(CACHE_SLOTS - 1);
  localparam logic [2:0] RankLast = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_AGE,
    ST_DERIVE,
    ST_JITTER,
    ST_WRITE,
    ST_RANK,
    ST_DONE
  } state_e;

  // Configuration registers
  logic [3:0]  w_etx_q, w_delay_q, w_jitter_q, w_rel_q, w_bw_q;
  logic [31:0] fresh_q;

  // Sequencer and item registers
  state_e      state_q, state_d;
  qlmc_in_t    item_q, item_d;
  logic [AW-1:0] idx_q, idx_d, chk_idx_q, chk_idx_d, slot_q, slot_d, rp_q, rp_d;
  logic        chk_vld_q, chk_vld_d, found_q, found_d, hit_q, hit_d;
  logic [CACHE_SLOTS-1:0] valid_q, valid_d;
  slot_rec_t   rec_q, rec_d;
  logic [15:0] prev_delay_q, prev_delay_d;
  logic [2:0]  step_q, step_d;

  // Metric registers
  logic [7:0]  etx_q, etx_d;
  logic [15:0] delay_q, delay_d, jitter_q, jitter_d;
  logic [6:0]  rel_q, rel_d;
  logic [7:0]  bw_q, bw_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  qlmc_out_t   out_q, out_d;

  // Slot RAM and rank unit
  logic        ram_we;
  slot_rec_t   ram_wdata, ram_rdata;
  logic [AW-1:0] ram_raddr;
  mac_ctl_t    mac_ctl;
  logic [AccW-1:0] acc;

  // Datapath helpers
  logic [14:0] rel_prod;
  logic [15:0] bw_prod;
  logic [8:0]  cost_comp;
  logic [31:0] age;
  logic        match;

  qlmc_ram #(
    .Width ($bits(slot_rec_t)),
    .Depth (CACHE_SLOTS),
    .AddrW (AW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  qlmc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .acc_o  (acc)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ram_raddr = idx_q;
  assign ram_we    = (state_q == ST_WRITE);
  assign ram_wdata = '{neighbor:    item_q.neighbor_id,
                       etx:         etx_q,
                       delay:       delay_q,
                       jitter:      jitter_q,
                       reliability: rel_q,
                       bandwidth:   bw_q,
                       stamp:       item_q.now};

  assign match     = chk_vld_q && valid_q[chk_idx_q] &&
                     (ram_rdata.neighbor == item_q.neighbor_id);
  assign rel_prod  = 15'(item_q.link_cost) * 15'(RelMax);
  assign cost_comp = CostSpan - 9'(item_q.link_cost);
  assign bw_prod   = 16'(cost_comp) * 16'(BwMax);
  assign age       = item_q.now - rec_q.stamp;

  // Rank operand selection, one term per step
  always_comb begin
    mac_ctl = '{en: (state_q == ST_RANK), clr: (step_q == '0),
                operand: '0, weight: '0};
    case (step_q)
      3'd0: begin
        mac_ctl.operand = 16'(etx_q);
        mac_ctl.weight  = w_etx_q;
      end
      3'd1: begin
        mac_ctl.operand = delay_q;
        mac_ctl.weight  = w_delay_q;
      end
      3'd2: begin
        mac_ctl.operand = jitter_q;
        mac_ctl.weight  = w_jitter_q;
      end
      3'd3: begin
        mac_ctl.operand = 16'(RelMax - 8'(rel_q));
        mac_ctl.weight  = w_rel_q;
      end
      default: begin
        mac_ctl.operand = 16'(BwMax - bw_q);
        mac_ctl.weight  = w_bw_q;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    idx_d        = idx_q;
    chk_idx_d    = chk_idx_q;
    chk_vld_d    = chk_vld_q;
    slot_d       = slot_q;
    rp_d         = rp_q;
    found_d      = found_q;
    hit_d        = hit_q;
    valid_d      = valid_q;
    rec_d        = rec_q;
    prev_delay_d = prev_delay_q;
    step_d       = step_q;
    etx_d        = etx_q;
    delay_d      = delay_q;
    jitter_d     = jitter_q;
    rel_d        = rel_q;
    bw_d         = bw_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_data_i;
          idx_d     = '0;
          chk_vld_d = 1'b0;
          state_d   = ST_SEARCH;
        end
      end

      // Issue one slot read per cycle, check the slot read the cycle before
      ST_SEARCH: begin
        if (match) begin
          found_d = 1'b1;
          slot_d  = chk_idx_q;
          rec_d   = ram_rdata;
          state_d = (item_q.func == FUNC_UPDATE) ? ST_DERIVE : ST_AGE;
        end else if (chk_vld_q && (chk_idx_q == LastSlot)) begin
          found_d = 1'b0;
          state_d = (item_q.func == FUNC_UPDATE) ? ST_DERIVE : ST_AGE;
        end else begin
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q;
          if (idx_q != LastSlot) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      // Lookup: freshness check of the first match
      ST_AGE: begin
        step_d = '0;
        if (found_q && (age < fresh_q)) begin
          hit_d    = 1'b1;
          etx_d    = rec_q.etx;
          delay_d  = rec_q.delay;
          jitter_d = rec_q.jitter;
          rel_d    = rec_q.reliability;
          bw_d     = rec_q.bandwidth;
          state_d  = ST_RANK;
        end else begin
          hit_d    = 1'b0;
          etx_d    = '0;
          delay_d  = '0;
          jitter_d = '0;
          rel_d    = '0;
          bw_d     = '0;
          state_d  = ST_DONE;
        end
      end

      // Update: delay, reliability, bandwidth and target slot
      ST_DERIVE: begin
        hit_d   = 1'b1;
        etx_d   = item_q.link_cost;
        delay_d = 16'(item_q.link_cost) + DelayBias + item_q.queue_wait;
        rel_d   = 7'(RelMax - 8'(rel_prod[14:8]));
        bw_d    = bw_prod[15:8];
        if (!found_q) begin
          slot_d = rp_q;
          rp_d   = (rp_q == LastSlot) ? '0 : rp_q + 1'b1;
        end
        state_d = ST_JITTER;
      end

      ST_JITTER: begin
        if (prev_delay_q == '0) begin
          jitter_d = '0;
        end else if (delay_q > prev_delay_q) begin
          jitter_d = delay_q - prev_delay_q;
        end else begin
          jitter_d = prev_delay_q - delay_q;
        end
        prev_delay_d = delay_q;
        state_d      = ST_WRITE;
      end

      ST_WRITE: begin
        valid_d[slot_q] = 1'b1;
        step_d          = '0;
        state_d         = ST_RANK;
      end

      // Five multiply-accumulate steps on the shared unit
      ST_RANK: begin
        step_d = step_q + 1'b1;
        if (step_q == RankLast) begin
          state_d = ST_DONE;
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d = '{hit:             hit_q,
                    etx_out:         etx_q,
                    delay_out:       delay_q,
                    jitter_out:      jitter_q,
                    reliability_out: rel_q,
                    bandwidth_out:   bw_q,
                    rank_out:        hit_q ? acc[19:4] : '0};
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, item and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      item_q       <= '0;
      idx_q        <= '0;
      chk_idx_q    <= '0;
      chk_vld_q    <= 1'b0;
      slot_q       <= '0;
      rp_q         <= '0;
      found_q      <= 1'b0;
      hit_q        <= 1'b0;
      valid_q      <= '0;
      rec_q        <= '0;
      prev_delay_q <= '0;
      step_q       <= '0;
      etx_q        <= '0;
      delay_q      <= '0;
      jitter_q     <= '0;
      rel_q        <= '0;
      bw_q         <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      idx_q        <= idx_d;
      chk_idx_q    <= chk_idx_d;
      chk_vld_q    <= chk_vld_d;
      slot_q       <= slot_d;
      rp_q         <= rp_d;
      found_q      <= found_d;
      hit_q        <= hit_d;
      valid_q      <= valid_d;
      rec_q        <= rec_d;
      prev_delay_q <= prev_delay_d;
      step_q       <= step_d;
      etx_q        <= etx_d;
      delay_q      <= delay_d;
      jitter_q     <= jitter_d;
      rel_q        <= rel_d;
      bw_q         <= bw_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_etx_q    <= WeightEtxRst;
      w_delay_q  <= WeightDelayRst;
      w_jitter_q <= WeightJitterRst;
      w_rel_q    <= WeightRelRst;
      w_bw_q     <= WeightBwRst;
      fresh_q    <= FreshRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WEIGHT_ETX:    w_etx_q    <= cfg_data_i[3:0];
        CFG_WEIGHT_DELAY:  w_delay_q  <= cfg_data_i[3:0];
        CFG_WEIGHT_JITTER: w_jitter_q <= cfg_data_i[3:0];
        CFG_WEIGHT_REL:    w_rel_q    <= cfg_data_i[3:0];
        CFG_WEIGHT_BW:     w_bw_q     <= cfg_data_i[3:0];
        CFG_FRESH:         fresh_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

@@ bench/qos_link_metric_cache_tb.sv @@
`timescale 1ns / 1ps

module qos_link_metric_cache_tb;
  import qlmc_pkg::*;

  // Cache and metric predictor, holds results still owed by the block
  class metric_scoreboard;
    logic [3:0]  wt_etx, wt_delay, wt_jitter, wt_rel, wt_bw;
    logic [31:0] fresh_ticks;
    bit          slot_used  [CacheSlotsDef];
    logic [7:0]  slot_id    [CacheSlotsDef];
    logic [7:0]  slot_etx   [CacheSlotsDef];
    logic [15:0] slot_delay [CacheSlotsDef];
    logic [15:0] slot_jit   [CacheSlotsDef];
    logic [6:0]  slot_rel   [CacheSlotsDef];
    logic [7:0]  slot_bw    [CacheSlotsDef];
    logic [31:0] slot_stamp [CacheSlotsDef];
    int unsigned evict_ptr;
    logic [15:0] prev_dly;
    qlmc_out_t   pending [$];
    int unsigned mismatches;

    function new();
      wt_etx      = WeightEtxRst;
      wt_delay    = WeightDelayRst;
      wt_jitter   = WeightJitterRst;
      wt_rel      = WeightRelRst;
      wt_bw       = WeightBwRst;
      fresh_ticks = FreshRst;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      evict_ptr   = 0;
      prev_dly    = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_WEIGHT_ETX:    wt_etx = data[3:0];
        CFG_WEIGHT_DELAY:  wt_delay = data[3:0];
        CFG_WEIGHT_JITTER: wt_jitter = data[3:0];
        CFG_WEIGHT_REL:    wt_rel = data[3:0];
        CFG_WEIGHT_BW:     wt_bw = data[3:0];
        CFG_FRESH:         fresh_ticks = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] rank_of_metrics(qlmc_out_t m);
      int unsigned sum;
      sum = int'(m.etx_out) * int'(wt_etx)
          + int'(m.delay_out) * int'(wt_delay)
          + int'(m.jitter_out) * int'(wt_jitter)
          + (100 - int'(m.reliability_out)) * int'(wt_rel)
          + (250 - int'(m.bandwidth_out)) * int'(wt_bw);
      return 16'(sum >> 4);
    endfunction

    // First valid slot holding the id, -1 if none
    function int find_slot(logic [7:0] id);
      for (int i = 0; i < CacheSlotsDef; i++) begin
        if (slot_used[i] && slot_id[i] == id) return i;
      end
      return -1;
    endfunction

    function void note_item(qlmc_in_t it);
      qlmc_out_t   res;
      int          idx;
      int unsigned link, dly, jit;
      logic [31:0] age;
      res = '0;
      idx = find_slot(it.neighbor_id);
      if (it.func == FUNC_UPDATE) begin
        link = 32'(it.link_cost);
        dly  = (link + 10 + int'(it.queue_wait)) & 32'hFFFF;
        jit  = 0;
        if (prev_dly != 0) begin
          jit = (dly > prev_dly) ? dly - prev_dly : prev_dly - dly;
        end
        prev_dly            = dly[15:0];
        res.hit             = 1'b1;
        res.etx_out         = link[7:0];
        res.delay_out       = dly[15:0];
        res.jitter_out      = jit[15:0];
        res.reliability_out = 7'(100 - (link * 100) / 256);
        res.bandwidth_out   = 8'((250 * (256 - link)) >> 8);
        res.rank_out        = rank_of_metrics(res);
        // new id takes the round-robin slot
        if (idx < 0) begin
          idx       = int'(evict_ptr);
          evict_ptr = (evict_ptr + 1) % CacheSlotsDef;
        end
        slot_used[idx]  = 1'b1;
        slot_id[idx]    = it.neighbor_id;
        slot_etx[idx]   = res.etx_out;
        slot_delay[idx] = res.delay_out;
        slot_jit[idx]   = res.jitter_out;
        slot_rel[idx]   = res.reliability_out;
        slot_bw[idx]    = res.bandwidth_out;
        slot_stamp[idx] = it.now;
      end else if (idx >= 0) begin
        age = it.now - slot_stamp[idx];
        if (age < fresh_ticks) begin
          res.hit             = 1'b1;
          res.etx_out         = slot_etx[idx];
          res.delay_out       = slot_delay[idx];
          res.jitter_out      = slot_jit[idx];
          res.reliability_out = slot_rel[idx];
          res.bandwidth_out   = slot_bw[idx];
          res.rank_out        = rank_of_metrics(res);
        end
      end
      pending.push_back(res);
    endfunction

    function void check_field(string fld, int unsigned want, int unsigned seen);
      if (want != seen) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on %s: expected 0x%0h, got 0x%0h", fld, want, seen);
        end
      end
    endfunction

    function void check_result(qlmc_out_t got);
      qlmc_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with none outstanding: %p", got);
        return;
      end
      want = pending.pop_front();
      check_field("hit", want.hit, got.hit);
      check_field("etx_out", want.etx_out, got.etx_out);
      check_field("delay_out", want.delay_out, got.delay_out);
      check_field("jitter_out", want.jitter_out, got.jitter_out);
      check_field("reliability_out", want.reliability_out, got.reliability_out);
      check_field("bandwidth_out", want.bandwidth_out, got.bandwidth_out);
      check_field("rank_out", want.rank_out, got.rank_out);
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  qlmc_in_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  qlmc_out_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]        cfg_data_i  = '0;

  metric_scoreboard sb = new();
  bit               quiet = 1'b0;
  logic [31:0]      tick = '0;
  logic [7:0]       id_pool [12];

  qos_link_metric_cache i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Receiver stalls in bursts, with clear stretches between them
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic send_item(qlmc_in_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  task automatic send_op(func_e f, logic [7:0] id, logic [7:0] link, logic [15:0] queue,
                         logic [31:0] now);
    qlmc_in_t it;
    it.func        = f;
    it.neighbor_id = id;
    it.link_cost   = link;
    it.queue_wait  = queue;
    it.now         = now;
    send_item(it);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  // Upper data bits are random to check the width masking
  task automatic program_regs(logic [3:0] we, logic [3:0] wd, logic [3:0] wj,
                              logic [3:0] wr, logic [3:0] wb, logic [31:0] fresh,
                              bit spare);
    write_reg(CFG_WEIGHT_ETX, {28'($urandom()), we});
    write_reg(CFG_WEIGHT_DELAY, {28'($urandom()), wd});
    write_reg(CFG_WEIGHT_JITTER, {28'($urandom()), wj});
    write_reg(CFG_WEIGHT_REL, {28'($urandom()), wr});
    write_reg(CFG_WEIGHT_BW, {28'($urandom()), wb});
    write_reg(CFG_FRESH, fresh);
    // unused indexes must be ignored
    if (spare) begin
      write_reg(CfgIdxW'(CFG_FRESH + 3'd1), $urandom());
      write_reg(CfgIdxW'(CFG_FRESH + 3'd2), $urandom());
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Block idle: input closed, every result back, pipeline drained
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * (CacheSlotsDef + 11)) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    qlmc_in_t it;
    logic [7:0] link;
    foreach (id_pool[i]) id_pool[i] = 8'($urandom());
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) tick = $urandom();
      else if ($urandom_range(0, 3) != 0) tick += $urandom_range(0, 48);
      case ($urandom_range(0, 7))
        0:       link = 8'd0;
        1:       link = 8'd255;
        default: link = 8'($urandom());
      endcase
      it.func        = ($urandom_range(0, 99) < 45) ? FUNC_LOOKUP : FUNC_UPDATE;
      it.neighbor_id = ($urandom_range(0, 6) == 0) ? 8'($urandom())
                                                   : id_pool[$urandom_range(0, 11)];
      it.link_cost   = link;
      case ($urandom_range(0, 9))
        0:       it.queue_wait = 16'hFFF6 - 16'(link);  // delay wraps to zero
        1, 2, 3: it.queue_wait = 16'($urandom());
        default: it.queue_wait = 16'($urandom_range(0, 2000));
      endcase
      it.now = tick;
      send_item(it);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cache, extremes, stale and wrapped ages, zero delay,
    // overwrite of a cached id, eviction by the round-robin pointer
    send_op(FUNC_LOOKUP, 8'h00, 8'h00, 16'h0000, 32'h0000_0000);
    send_op(FUNC_UPDATE, 8'h00, 8'h00, 16'h0000, 32'h0000_0000);
    send_op(FUNC_UPDATE, 8'hFF, 8'hFF, 16'hFFFF, 32'h0000_0064);
    send_op(FUNC_LOOKUP, 8'hFF, 8'hFF, 16'hFFFF, 32'h0000_0463);
    send_op(FUNC_LOOKUP, 8'hFF, 8'h00, 16'h0000, 32'h0000_0464);
    send_op(FUNC_UPDATE, 8'h5A, 8'h80, 16'h1234, 32'hFFFF_FF00);
    send_op(FUNC_LOOKUP, 8'h5A, 8'h00, 16'h0000, 32'h0000_0010);
    send_op(FUNC_UPDATE, 8'h33, 8'h06, 16'hFFF0, 32'h0000_0020);
    send_op(FUNC_UPDATE, 8'h33, 8'h40, 16'h8000, 32'h0000_0030);
    send_op(FUNC_LOOKUP, 8'h33, 8'h00, 16'h0000, 32'h0000_0040);
    for (int i = 0; i < 6; i++) begin
      send_op(FUNC_UPDATE, 8'hA1 + 8'(i), 8'(37 * i + 11), 16'(4111 * i), 32'h100 + 32'(i));
    end
    send_op(FUNC_LOOKUP, 8'h00, 8'h00, 16'h0000, 32'h0000_0200);
    send_op(FUNC_LOOKUP, 8'h5A, 8'h00, 16'h0000, 32'h0000_0200);
    send_op(FUNC_UPDATE, 8'h5A, 8'hC3, 16'h7FFF, 32'h0000_0210);
    send_op(FUNC_UPDATE, 8'h77, 8'h01, 16'h0001, 32'h0000_0220);
    send_op(FUNC_LOOKUP, 8'h5A, 8'h00, 16'h0000, 32'h0000_0230);
    send_op(FUNC_LOOKUP, 8'h77, 8'h00, 16'h0000, 32'h0000_0230);
    send_op(FUNC_LOOKUP, 8'hA6, 8'h00, 16'h0000, 32'h0000_0230);
    tick = 32'h0000_0240;

    run_random(268);

    settle();
    program_regs(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0);
    run_random(268);

    settle();
    program_regs(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 32'd0, 1'b0);
    run_random(268);

    settle();
    program_regs(4'($urandom()), 4'($urandom()), 4'($urandom()), 4'($urandom()),
                 4'($urandom()), 32'd200, 1'b1);
    run_random(268);

    settle();
    program_regs(4'($urandom()), 4'($urandom()), 4'($urandom()), 4'($urandom()),
                 4'($urandom()), 32'd1, 1'b0);
    run_random(268);

    settle();
    program_regs(4'($urandom()), 4'($urandom()), 4'($urandom()), 4'($urandom()),
                 4'($urandom()), 32'($urandom_range(64, 4096)), 1'b0);
    run_random(268);

    // closing stretch without idling on either side
    settle();
    quiet = 1'b1;
    program_regs(4'($urandom()), 4'($urandom()), 4'($urandom()), 4'($urandom()),
                 4'($urandom()), FreshRst, 1'b1);
    run_random(268);

    settle();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ qos_link_metric_cache.f @@
rtl/qlmc_pkg.sv
rtl/qlmc_ram.sv
rtl/qlmc_mac.sv
rtl/qos_link_metric_cache.sv
bench/qos_link_metric_cache_tb.sv
